// ===== sv/rope_pkg.sv =====
// Shared types, widths and constant tables for the rotary position embedding block.
package rope_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_HEAD_DIM_DEF = 256;
    localparam int CORDIC_STEPS_DEF = 16;

    // Field and datapath widths
    localparam int ELEM_W   = 16;
    localparam int PIDX_W   = 7;
    localparam int POS_W    = 20;
    localparam int HDIM_W   = 9;
    localparam int LOG2B_W  = 22;
    localparam int NUM_W    = PIDX_W + 1 + LOG2B_W;   // 2*p*L
    localparam int FRAC_W   = 16;                      // fraction bits of the exponent
    localparam int NSH_W    = NUM_W - FRAC_W;          // integer part of the exponent
    localparam int M_W      = 33;                      // 2^-f mantissa, Q.32 incl. 1.0
    localparam int INV_W    = 30;
    localparam int STEP_W   = M_W + INV_W - 16;        // phase step, Q.48 turns
    localparam int PP_W     = 48;                      // low bits of pos*step that matter
    localparam int PHASE_W  = 32;
    localparam int CX_W     = 34;                      // CORDIC x/y, Q.30 with headroom
    localparam int CZ_W     = 33;                      // CORDIC angle, turns Q.32 signed
    localparam int ATAN_LEN = 24;
    localparam int PROD_W   = CX_W + ELEM_W;

    // Register reset values
    localparam logic [HDIM_W-1:0]  HDIM_RST  = 9'd128;
    localparam logic [LOG2B_W-1:0] LOG2B_RST = 22'd870832;

    // Arithmetic constants
    localparam logic signed [CX_W-1:0] INV_GAIN_Q30   = 34'sh26DD3B6A;
    localparam logic [INV_W-1:0]       INV_TWO_PI_Q32 = 30'h28BE60DC;

    // atan(2^-i) in turns, Q.32
    localparam logic signed [CZ_W-1:0] ATAN_TBL [0:ATAN_LEN-1] = '{
        33'sh20000000, 33'sh12E4051E, 33'sh09FB385B, 33'sh051111D4,
        33'sh028B0D43, 33'sh0145D7E1, 33'sh00A2F61E, 33'sh00517C55,
        33'sh0028BE53, 33'sh00145F2F, 33'sh000A2F98, 33'sh000517CC,
        33'sh00028BE6, 33'sh000145F3, 33'sh0000A2FA, 33'sh0000517D,
        33'sh000028BE, 33'sh0000145F, 33'sh00000A30, 33'sh00000518,
        33'sh0000028C, 33'sh00000146, 33'sh000000A3, 33'sh00000051
    };

    // Register map
    typedef enum logic [0:0] {
        REG_HEAD_DIM  = 1'b0,
        REG_LOG2_BASE = 1'b1
    } rope_reg_t;

    // Quadrant taken out of the phase before the CORDIC
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } rope_quad_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_even;
        logic signed [ELEM_W-1:0] elem_odd;
        logic [PIDX_W-1:0]        pair_index;
        logic [POS_W-1:0]         token_position;
        logic                     row_end;
    } rope_in_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] rot_even;
        logic signed [ELEM_W-1:0] rot_odd;
        logic [PIDX_W-1:0]        pair_index_out;
        logic                     row_end_out;
    } rope_out_t;

    typedef logic [31:0] rope_ttbl_t [0:FRAC_W-1];

    // Integer square root, bit by bit
    function automatic logic [63:0] rope_isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        x = v;
        for (int k = 0; k < 32; k++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^-(2^(i-16)) in Q.32, entry i for exponent bit i
    function automatic rope_ttbl_t rope_t_table();
        rope_ttbl_t tbl;
        logic [63:0] t;
        t = rope_isqrt64(64'h8000_0000_0000_0000);
        for (int i = FRAC_W - 1; i >= 0; i--) begin
            tbl[i] = t[31:0];
            t = rope_isqrt64({t[31:0], 32'h0});
        end
        return tbl;
    endfunction

    localparam rope_ttbl_t T_TBL = rope_t_table();

endpackage

// ===== sv/rope_div.sv =====
// Pipelined restoring divider: exponent e = floor(2*p*L / d), one quotient bit per stage.
module rope_div import rope_pkg::*; #(
    parameter int DW = 9
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  logic [NUM_W-1:0]  in_num,
    input  rope_in_t          in_side,
    input  logic [DW-1:0]     dvsr,
    output logic              out_vld,
    output logic [NUM_W-1:0]  out_quo,
    output rope_in_t          out_side
);

    logic [NUM_W-1:0] vld_reg;
    logic [DW-1:0]    rem_reg  [0:NUM_W-1];
    logic [DW-1:0]    rem_next [0:NUM_W-1];
    logic [NUM_W-1:0] num_reg  [0:NUM_W-1];
    logic [NUM_W-1:0] quo_reg  [0:NUM_W-1];
    logic [NUM_W-1:0] quo_next [0:NUM_W-1];
    rope_in_t         side_reg [0:NUM_W-1];

    logic [DW-1:0]    rem_in  [0:NUM_W-1];
    logic [NUM_W-1:0] num_in  [0:NUM_W-1];
    logic [NUM_W-1:0] quo_in  [0:NUM_W-1];
    rope_in_t         side_in [0:NUM_W-1];
    logic [DW:0]      trial   [0:NUM_W-1];

    // stage inputs: first stage from the ports, the rest from the previous stage
    always_comb begin
        rem_in[0]  = '0;
        num_in[0]  = in_num;
        quo_in[0]  = '0;
        side_in[0] = in_side;
        for (int j = 1; j < NUM_W; j++) begin
            rem_in[j]  = rem_reg[j-1];
            num_in[j]  = num_reg[j-1];
            quo_in[j]  = quo_reg[j-1];
            side_in[j] = side_reg[j-1];
        end
    end

    // one compare-subtract per stage, MSB first
    always_comb begin
        for (int j = 0; j < NUM_W; j++) begin
            trial[j]    = {rem_in[j], num_in[j][NUM_W-1-j]};
            quo_next[j] = quo_in[j];
            if (trial[j] >= {1'b0, dvsr}) begin
                rem_next[j] = DW'(trial[j] - {1'b0, dvsr});
                quo_next[j][NUM_W-1-j] = 1'b1;
            end else begin
                rem_next[j] = trial[j][DW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NUM_W-2:0], in_vld};
        end
        if (en) begin
            for (int j = 0; j < NUM_W; j++) begin
                rem_reg[j]  <= rem_next[j];
                num_reg[j]  <= num_in[j];
                quo_reg[j]  <= quo_next[j];
                side_reg[j] <= side_in[j];
            end
        end
    end

    assign out_vld  = vld_reg[NUM_W-1];
    assign out_quo  = quo_reg[NUM_W-1];
    assign out_side = side_reg[NUM_W-1];

endmodule

// ===== sv/rope_exp2.sv =====
// Exponent to phase: 2^-f by one multiply per fraction bit, scale to turns, shift, times position.
module rope_exp2 import rope_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_vld,
    input  logic [NUM_W-1:0]    in_e,
    input  rope_in_t            in_side,
    output logic                out_vld,
    output logic [PHASE_W-1:0]  out_phase,
    output rope_in_t            out_side
);

    localparam int NST   = FRAC_W + 3;
    localparam int PRD_W = M_W + 32;
    localparam int SPR_W = M_W + INV_W;

    logic [NST-1:0]   vld_reg;

    // fraction multiply stages
    logic [M_W-1:0]   m_reg    [0:FRAC_W-1];
    logic [M_W-1:0]   m_next   [0:FRAC_W-1];
    logic [NUM_W-1:0] e_reg    [0:FRAC_W-1];
    rope_in_t         side_reg [0:FRAC_W-1];
    logic [M_W-1:0]   m_in     [0:FRAC_W-1];
    logic [NUM_W-1:0] e_in     [0:FRAC_W-1];
    rope_in_t         side_in  [0:FRAC_W-1];
    logic [PRD_W-1:0] prod     [0:FRAC_W-1];

    // tail stages
    logic [SPR_W-1:0]   sprod;
    logic [STEP_W-1:0]  step_reg;
    logic [NSH_W-1:0]   nsh_reg;
    rope_in_t           side1_reg;
    logic [STEP_W-1:0]  sh_reg;
    rope_in_t           side2_reg;
    logic [PP_W-1:0]    pprod;
    logic [PHASE_W-1:0] phase_reg;
    rope_in_t           side3_reg;

    always_comb begin
        m_in[0]    = {1'b1, 32'h0};
        e_in[0]    = in_e;
        side_in[0] = in_side;
        for (int k = 1; k < FRAC_W; k++) begin
            m_in[k]    = m_reg[k-1];
            e_in[k]    = e_reg[k-1];
            side_in[k] = side_reg[k-1];
        end
    end

    // stage k applies exponent bit FRAC_W-1-k
    always_comb begin
        for (int k = 0; k < FRAC_W; k++) begin
            prod[k] = PRD_W'(m_in[k]) * PRD_W'(T_TBL[FRAC_W-1-k]);
            if (e_in[k][FRAC_W-1-k]) begin
                m_next[k] = prod[k][M_W+31:32];
            end else begin
                m_next[k] = m_in[k];
            end
        end
    end

    // scale to turns, and position times step
    assign sprod = SPR_W'(m_reg[FRAC_W-1]) * SPR_W'(INV_TWO_PI_Q32);
    assign pprod = PP_W'(side2_reg.token_position) * PP_W'(sh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], in_vld};
        end
        if (en) begin
            for (int k = 0; k < FRAC_W; k++) begin
                m_reg[k]    <= m_next[k];
                e_reg[k]    <= e_in[k];
                side_reg[k] <= side_in[k];
            end
            step_reg  <= sprod[STEP_W+15:16];
            nsh_reg   <= e_reg[FRAC_W-1][NUM_W-1:FRAC_W];
            side1_reg <= side_reg[FRAC_W-1];
            // shift of STEP_W or more clears the step
            sh_reg    <= step_reg >> nsh_reg;
            side2_reg <= side1_reg;
            phase_reg <= pprod[PHASE_W+15:16];
            side3_reg <= side2_reg;
        end
    end

    assign out_vld   = vld_reg[NST-1];
    assign out_phase = phase_reg;
    assign out_side  = side3_reg;

endmodule

// ===== sv/rope_cordic.sv =====
// Quadrant fold and unrolled CORDIC rotation, one micro-rotation per stage.
module rope_cordic import rope_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_vld,
    input  logic [PHASE_W-1:0]      in_phase,
    input  rope_in_t                in_side,
    output logic                    out_vld,
    output logic signed [CX_W-1:0]  out_x,
    output logic signed [CX_W-1:0]  out_y,
    output rope_quad_t              out_q,
    output rope_in_t                out_side
);

    localparam int CS = CORDIC_STEPS;

    logic [PHASE_W-1:0] psum;
    logic [PHASE_W-1:0] res;
    logic [CS-1:0]      vld_reg;

    logic signed [CX_W-1:0] x_reg  [0:CS-1];
    logic signed [CX_W-1:0] y_reg  [0:CS-1];
    logic signed [CZ_W-1:0] z_reg  [0:CS-1];
    rope_quad_t             q_reg  [0:CS-1];
    rope_in_t               side_reg [0:CS-1];

    logic signed [CX_W-1:0] x_in [0:CS-1];
    logic signed [CX_W-1:0] y_in [0:CS-1];
    logic signed [CZ_W-1:0] z_in [0:CS-1];
    rope_quad_t             q_in [0:CS-1];
    rope_in_t               side_in [0:CS-1];

    logic signed [CX_W-1:0] x_next [0:CS-1];
    logic signed [CX_W-1:0] y_next [0:CS-1];
    logic signed [CZ_W-1:0] z_next [0:CS-1];

    // nearest quarter turn and signed residual
    assign psum = in_phase + 32'h2000_0000;
    assign res  = in_phase - {psum[PHASE_W-1:PHASE_W-2], 30'h0};

    always_comb begin
        x_in[0]    = INV_GAIN_Q30;
        y_in[0]    = '0;
        z_in[0]    = {res[PHASE_W-1], res};
        q_in[0]    = rope_quad_t'(psum[PHASE_W-1:PHASE_W-2]);
        side_in[0] = in_side;
        for (int i = 1; i < CS; i++) begin
            x_in[i]    = x_reg[i-1];
            y_in[i]    = y_reg[i-1];
            z_in[i]    = z_reg[i-1];
            q_in[i]    = q_reg[i-1];
            side_in[i] = side_reg[i-1];
        end
    end

    // micro-rotations; nonnegative angle rotates positive
    always_comb begin
        for (int i = 0; i < CS; i++) begin
            if (!z_in[i][CZ_W-1]) begin
                x_next[i] = x_in[i] - (y_in[i] >>> i);
                y_next[i] = y_in[i] + (x_in[i] >>> i);
                z_next[i] = z_in[i] - ATAN_TBL[i];
            end else begin
                x_next[i] = x_in[i] + (y_in[i] >>> i);
                y_next[i] = y_in[i] - (x_in[i] >>> i);
                z_next[i] = z_in[i] + ATAN_TBL[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[CS-2:0], in_vld};
        end
        if (en) begin
            for (int i = 0; i < CS; i++) begin
                x_reg[i]    <= x_next[i];
                y_reg[i]    <= y_next[i];
                z_reg[i]    <= z_next[i];
                q_reg[i]    <= q_in[i];
                side_reg[i] <= side_in[i];
            end
        end
    end

    assign out_vld  = vld_reg[CS-1];
    assign out_x    = x_reg[CS-1];
    assign out_y    = y_reg[CS-1];
    assign out_q    = q_reg[CS-1];
    assign out_side = side_reg[CS-1];

endmodule

// ===== sv/rope_rot.sv =====
// Quadrant unfold, rotation products, rounding and saturation into the output register.
module rope_rot import rope_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_vld,
    input  logic signed [CX_W-1:0]  in_x,
    input  logic signed [CX_W-1:0]  in_y,
    input  rope_quad_t              in_q,
    input  rope_in_t                in_side,
    output logic                    out_vld,
    output rope_out_t               out_data
);

    localparam int SUM_W = PROD_W + 1;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << 29);

    logic signed [CX_W-1:0]   cos_v;
    logic signed [CX_W-1:0]   sin_v;
    logic signed [PROD_W-1:0] xc_reg, ys_reg, xs_reg, yc_reg;
    rope_in_t                 side_reg;
    logic                     vld_reg;
    logic signed [SUM_W-1:0]  sum_a, sum_b;
    rope_out_t                out_reg;
    rope_out_t                out_next;
    logic                     out_vld_reg;

    function automatic logic signed [ELEM_W-1:0] sat_elem(input logic signed [SUM_W-1:0] v);
        if (v[SUM_W-1:ELEM_W-1] != {(SUM_W-ELEM_W+1){v[SUM_W-1]}}) begin
            return v[SUM_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
        end
        return v[ELEM_W-1:0];
    endfunction

    // rotate (x, y) back by the folded quarter turns
    always_comb begin
        case (in_q)
            QUAD_0: begin
                cos_v = in_x;
                sin_v = in_y;
            end
            QUAD_90: begin
                cos_v = -in_y;
                sin_v = in_x;
            end
            QUAD_180: begin
                cos_v = -in_x;
                sin_v = -in_y;
            end
            QUAD_270: begin
                cos_v = in_y;
                sin_v = -in_x;
            end
            default: begin
                cos_v = in_x;
                sin_v = in_y;
            end
        endcase
    end

    // round half up at Q.30, then saturate
    always_comb begin
        sum_a = SUM_W'(xc_reg) - SUM_W'(ys_reg) + ROUND_HALF;
        sum_b = SUM_W'(xs_reg) + SUM_W'(yc_reg) + ROUND_HALF;
        out_next.rot_even       = sat_elem(sum_a >>> 30);
        out_next.rot_odd        = sat_elem(sum_b >>> 30);
        out_next.pair_index_out = side_reg.pair_index;
        out_next.row_end_out    = side_reg.row_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= in_vld;
            out_vld_reg <= vld_reg;
        end
        if (en) begin
            xc_reg   <= PROD_W'(in_side.elem_even) * PROD_W'(cos_v);
            ys_reg   <= PROD_W'(in_side.elem_odd)  * PROD_W'(sin_v);
            xs_reg   <= PROD_W'(in_side.elem_even) * PROD_W'(sin_v);
            yc_reg   <= PROD_W'(in_side.elem_odd)  * PROD_W'(cos_v);
            side_reg <= in_side;
            out_reg  <= out_next;
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_data = out_reg;

endmodule

// ===== sv/rotary_position_embedding.sv =====
// Top level of the rotary position embedding block: register port, input stage, pipeline.
//
// Rotates one element pair (x, y) per clock by pos * theta^(-2p/d) while the pipeline is not
// held. A pair is taken every cycle unless the pipeline holds; its result passes through one
// input stage, a 30-stage divider for 2p*log2(theta)/d, 16 multiply stages for 2^-f plus
// three stages for turns scaling, shift and position multiply, one stage per CORDIC
// iteration, and two stages for the rotation products and rounding. The whole pipeline
// holds while a finished transaction waits at the output, so s_ready follows m_ready when
// the output register is full. Registers: head dimension in use at 0x0, log2 of the base
// at 0x4; write them only while no transaction is in flight.
module rotary_position_embedding import rope_pkg::*; #(
    parameter int MAX_HEAD_DIM = MAX_HEAD_DIM_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input pairs
    input  logic        s_valid,
    output logic        s_ready,
    input  rope_in_t    s_data,
    // rotated pairs
    output logic        m_valid,
    input  logic        m_ready,
    output rope_out_t   m_data,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW = $clog2(MAX_HEAD_DIM + 1);

    logic [HDIM_W-1:0]  hdim_reg;
    logic [LOG2B_W-1:0] log2_base_reg;
    logic               wr_en;
    rope_reg_t          reg_sel;

    logic               en;
    logic [DW-1:0]      d_eff;
    logic [NUM_W-1:0]   num_next;
    logic [NUM_W-1:0]   num_reg;
    rope_in_t           side0_reg;
    logic               vld0_reg;

    logic               div_vld;
    logic [NUM_W-1:0]   div_e;
    rope_in_t           div_side;
    logic               exp_vld;
    logic [PHASE_W-1:0] exp_phase;
    rope_in_t           exp_side;
    logic               cor_vld;
    logic signed [CX_W-1:0] cor_x;
    logic signed [CX_W-1:0] cor_y;
    rope_quad_t         cor_q;
    rope_in_t           cor_side;

    // register port
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = rope_reg_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdim_reg      <= HDIM_RST;
            log2_base_reg <= LOG2B_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_HEAD_DIM:  hdim_reg      <= pwdata[HDIM_W-1:0];
                REG_LOG2_BASE: log2_base_reg <= pwdata[LOG2B_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_HEAD_DIM:  prdata = 32'(hdim_reg);
            REG_LOG2_BASE: prdata = 32'(log2_base_reg);
            default:       prdata = '0;
        endcase
    end

    // clamp the head dimension to [2, MAX_HEAD_DIM]
    always_comb begin
        if (int'(hdim_reg) < 2) begin
            d_eff = DW'(2);
        end else if (int'(hdim_reg) > MAX_HEAD_DIM) begin
            d_eff = DW'(MAX_HEAD_DIM);
        end else begin
            d_eff = DW'(hdim_reg);
        end
    end

    // global advance: stall only when the output register is full and not taken
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // input stage: numerator 2*p*L
    assign num_next = NUM_W'({s_data.pair_index, 1'b0}) * NUM_W'(log2_base_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= 1'b0;
        end else if (en) begin
            vld0_reg <= s_valid;
        end
        if (en) begin
            num_reg   <= num_next;
            side0_reg <= s_data;
        end
    end

    rope_div #(
        .DW (DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (vld0_reg),
        .in_num   (num_reg),
        .in_side  (side0_reg),
        .dvsr     (d_eff),
        .out_vld  (div_vld),
        .out_quo  (div_e),
        .out_side (div_side)
    );

    rope_exp2 u_exp2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_vld    (div_vld),
        .in_e      (div_e),
        .in_side   (div_side),
        .out_vld   (exp_vld),
        .out_phase (exp_phase),
        .out_side  (exp_side)
    );

    rope_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (exp_vld),
        .in_phase (exp_phase),
        .in_side  (exp_side),
        .out_vld  (cor_vld),
        .out_x    (cor_x),
        .out_y    (cor_y),
        .out_q    (cor_q),
        .out_side (cor_side)
    );

    rope_rot u_rot (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (cor_vld),
        .in_x     (cor_x),
        .in_y     (cor_y),
        .in_q     (cor_q),
        .in_side  (cor_side),
        .out_vld  (m_valid),
        .out_data (m_data)
    );

endmodule
